// ===== rtl/core/fntc_pkg.sv =====
// fntc_pkg: types, constants and helper functions for the terrain noise classifier.
// No dependencies.
package fntc_pkg;

    localparam int OCTAVES_DEF   = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_W         = 18;

    localparam logic [31:0] HASH_KX  = 32'h1f123bb5;
    localparam logic [31:0] HASH_KY  = 32'h9e3779b9;
    localparam logic [31:0] MIX_ADD  = 32'h9e3779b9;
    localparam logic [31:0] MIX_M1   = 32'h85ebca6b;
    localparam logic [31:0] MIX_M2   = 32'hc2b2ae35;
    localparam logic [31:0] SEED_STEP = 32'd1013;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } fntc_in_t;

    typedef struct packed {
        logic signed [17:0] noise_sum;
        logic [1:0]         tile_index;
    } fntc_out_t;

    localparam logic [1:0] TILE_LOW  = 2'd0;
    localparam logic [1:0] TILE_HIGH = 2'd2;

    function automatic int period_of(input int oct);
        int p;
        begin
            p = 20;
            case (oct)
                0: p = 20;
                1: p = 10;
                default: p = 5;
            endcase
            return p;
        end
    endfunction

endpackage

// ===== rtl/core/fractal_noise_terrain_classifier.sv =====
// fractal_noise_terrain_classifier: top level, octave pipelines, weighted sum, classifier.
// Depends on fntc_pkg and fntc_octave.
//
//  channel  | signals                   | dir | payload
//  in       | in_valid, in_ready, in_data   | in  | fntc_in_t
//  out      | out_valid, out_ready, out_data| out | fntc_out_t
//  cfg      | cfg_we, cfg_data              | in  | seed_word
//
// One item per cycle while the output is not stalled; 10 octave stages, then the sum into the output register.
// The whole pipeline advances together; a stalled output holds every stage,
// bubbles included, and in_ready follows out_ready while the output is full.
// Reset clears valid bits and the seed.
module fractal_noise_terrain_classifier #(
    parameter int OCTAVES   = fntc_pkg::OCTAVES_DEF,
    parameter int FRAC_BITS = fntc_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fntc_pkg::fntc_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fntc_pkg::fntc_out_t out_data,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data
);
    localparam int QW  = FRAC_BITS + 4;
    localparam int LAT = 11;
    localparam int NOCT = (OCTAVES > 3) ? 3 : OCTAVES;
    localparam int SW = QW + 2;

    logic [31:0]    seed_reg;
    logic [LAT-1:0] vld_reg;
    logic           en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_we)
            seed_reg <= cfg_data;
    end

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    logic signed [QW-1:0] oct_n [NOCT];

    for (genvar i = 0; i < NOCT; i++)
    begin : g_oct
        fntc_octave #(
            .PERIOD    (fntc_pkg::period_of(i)),
            .FRAC_BITS (FRAC_BITS),
            .OCT       (i)
        ) u_oct (
            .clk   (clk),
            .en    (en),
            .cx    (in_data.coord_x),
            .cy    (in_data.coord_y),
            .seed  (seed_reg),
            .noise (oct_n[i])
        );
    end

    // octave weights: shift toward zero
    logic signed [SW-1:0] sum_c;
    logic signed [QW-1:0] term_c;
    always_comb
    begin
        sum_c  = '0;
        term_c = '0;
        for (int i = 0; i < NOCT; i++)
        begin
            term_c = oct_n[i];
            if (term_c < 0)
                term_c = term_c + QW'((1 << i) - 1);
            sum_c = sum_c + SW'(term_c >>> i);
        end
    end

    fntc_pkg::fntc_out_t out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sum_c > SW'(131071))
                out_reg.noise_sum <= 18'sd131071;
            else if (sum_c < -SW'(131072))
                out_reg.noise_sum <= -18'sd131072;
            else
                out_reg.noise_sum <= 18'(sum_c);
            out_reg.tile_index <= sum_c[SW-1] ? fntc_pkg::TILE_LOW : fntc_pkg::TILE_HIGH;
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/fntc_octave.sv =====
// fntc_octave: pipelined single-octave gradient noise (cell split, hash, dots, fade, lerp).
// Depends on fntc_pkg. Advances when en is high.
module fntc_octave #(
    parameter int PERIOD    = 20,
    parameter int FRAC_BITS = fntc_pkg::FRAC_BITS_DEF,
    parameter int OCT       = 0
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  cx,
    input  logic signed [31:0]  cy,
    input  logic [31:0]         seed,
    output logic signed [FRAC_BITS+3:0] noise
);
    localparam int QW = FRAC_BITS + 5;
    localparam int PW = 2 * QW + 2;
    localparam longint QONE = 64'sd1 << FRAC_BITS;
    localparam longint QDIAG = (64'sd7071 << FRAC_BITS) / 64'sd10000;
    localparam int RW = $clog2(PERIOD);
    localparam logic [31:0] OFFS = fntc_pkg::SEED_STEP * OCT;
    localparam int PSH = (PERIOD % 4 == 0) ? 2 : ((PERIOD % 2 == 0) ? 1 : 0);
    localparam longint P_ODD = PERIOD >> PSH;
    localparam logic [31:0] RECIP = 32'(((64'sd1 <<< 34) + P_ODD - 64'sd1) / P_ODD);

    typedef logic signed [QW-1:0] q_t;

    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] r;
        begin
            p = PW'(a) * PW'(b);
            r = p / PW'(QONE);
            return q_t'(r);
        end
    endfunction

    // unsigned divide by period: shift out the power of two, reciprocal multiply by the rest
    function automatic logic [31:0] div_p(input logic [31:0] a);
        logic [31:0] s;
        logic [63:0] m;
        begin
            s = a >> PSH;
            m = 64'(s) * 64'(RECIP);
            return 32'(m >> 34);
        end
    endfunction

    // stage 1: floor divide by period (reciprocal multiply on the magnitude)
    logic signed [32:0] q1x_reg, q1y_reg;
    logic [RW-1:0]      r1x_reg, r1y_reg;
    logic [31:0]        s1_reg;

    function automatic logic signed [32:0] fdiv(input logic signed [31:0] c);
        logic [31:0] a;
        logic [31:0] q;
        begin
            a = c[31] ? ~c : c;
            q = div_p(a);
            return c[31] ? ~{1'b0, q} : {1'b0, q};
        end
    endfunction

    logic signed [32:0] qx_c, qy_c;
    assign qx_c = fdiv(cx);
    assign qy_c = fdiv(cy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1x_reg <= qx_c;
            q1y_reg <= qy_c;
            r1x_reg <= RW'(34'(cx) - 34'(qx_c) * 34'(PERIOD));
            r1y_reg <= RW'(34'(cy) - 34'(qy_c) * 34'(PERIOD));
            s1_reg  <= seed + OFFS;
        end
    end

    // stage 2: fractions, corner hash products
    q_t fx2_reg, fy2_reg;
    logic [31:0] hx0_reg, hx1_reg, hy0_reg, hy1_reg, s2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx2_reg <= q_t'(div_p(32'(r1x_reg) << FRAC_BITS));
            fy2_reg <= q_t'(div_p(32'(r1y_reg) << FRAC_BITS));
            hx0_reg <= q1x_reg[31:0] * fntc_pkg::HASH_KX;
            hx1_reg <= (q1x_reg[31:0] + 32'd1) * fntc_pkg::HASH_KX;
            hy0_reg <= q1y_reg[31:0] * fntc_pkg::HASH_KY;
            hy1_reg <= (q1y_reg[31:0] + 32'd1) * fntc_pkg::HASH_KY;
            s2_reg  <= s1_reg;
        end
    end

    // stage 3..5: golden-ratio add and murmur3 fmix32 finaliser per corner
    logic [31:0] m3_reg [4];
    logic [31:0] m4_reg [4];
    logic [2:0]  g5_reg [4];
    q_t fx3_reg, fy3_reg, fx4_reg, fy4_reg, fx5_reg, fy5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic [31:0] v;
                v = (((k & 1) != 0) ? hx1_reg : hx0_reg) ^
                    (((k & 2) != 0) ? hy1_reg : hy0_reg) ^ s2_reg;
                v = v + fntc_pkg::MIX_ADD;
                m3_reg[k] <= (v ^ (v >> 16)) * fntc_pkg::MIX_M1;
                m4_reg[k] <= (m3_reg[k] ^ (m3_reg[k] >> 13)) * fntc_pkg::MIX_M2;
                g5_reg[k] <= 3'(m4_reg[k] ^ (m4_reg[k] >> 16));
            end
            fx3_reg <= fx2_reg; fy3_reg <= fy2_reg;
            fx4_reg <= fx3_reg; fy4_reg <= fy3_reg;
            fx5_reg <= fx4_reg; fy5_reg <= fy4_reg;
        end
    end

    // stage 6: diagonal products, fade inner / square
    q_t ax6_reg [4], ay6_reg [4];
    logic [2:0] g6_reg [4];
    q_t fx6_reg, fy6_reg, iu6_reg, iv6_reg, su6_reg, sv6_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                q_t ox, oy;
                ox = ((k & 1) != 0) ? q_t'(fx5_reg - q_t'(QONE)) : fx5_reg;
                oy = ((k & 2) != 0) ? q_t'(fy5_reg - q_t'(QONE)) : fy5_reg;
                g6_reg[k] <= g5_reg[k];
                if (g5_reg[k][2])
                begin
                    ax6_reg[k] <= qmul(g5_reg[k][0] ? q_t'(-QDIAG) : q_t'(QDIAG), ox);
                    ay6_reg[k] <= qmul(g5_reg[k][1] ? q_t'(-QDIAG) : q_t'(QDIAG), oy);
                end
                else
                begin
                    ax6_reg[k] <= ox;
                    ay6_reg[k] <= oy;
                end
            end
            fx6_reg <= fx5_reg; fy6_reg <= fy5_reg;
            iu6_reg <= q_t'(qmul(fx5_reg, q_t'(6 * fx5_reg - q_t'(15 * QONE))) + q_t'(10 * QONE));
            iv6_reg <= q_t'(qmul(fy5_reg, q_t'(6 * fy5_reg - q_t'(15 * QONE))) + q_t'(10 * QONE));
            su6_reg <= qmul(fx5_reg, fx5_reg);
            sv6_reg <= qmul(fy5_reg, fy5_reg);
        end
    end

    // stage 7: dots, cube
    q_t d7_reg [4];
    q_t iu7_reg, iv7_reg, cu7_reg, cv7_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                case (g6_reg[k])
                    3'd0: d7_reg[k] <= ax6_reg[k];
                    3'd1: d7_reg[k] <= q_t'(-ax6_reg[k]);
                    3'd2: d7_reg[k] <= ay6_reg[k];
                    3'd3: d7_reg[k] <= q_t'(-ay6_reg[k]);
                    default: d7_reg[k] <= q_t'(ax6_reg[k] + ay6_reg[k]);
                endcase
            end
            iu7_reg <= iu6_reg; iv7_reg <= iv6_reg;
            cu7_reg <= qmul(su6_reg, fx6_reg);
            cv7_reg <= qmul(sv6_reg, fy6_reg);
        end
    end

    // stage 8: fades
    q_t d8_reg [4];
    q_t u8_reg, v8_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                d8_reg[k] <= d7_reg[k];
            u8_reg <= qmul(cu7_reg, iu7_reg);
            v8_reg <= qmul(cv7_reg, iv7_reg);
        end
    end

    // stage 9: x lerps
    q_t n09_reg, n19_reg, v9_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n09_reg <= q_t'(d8_reg[0] + qmul(u8_reg, q_t'(d8_reg[1] - d8_reg[0])));
            n19_reg <= q_t'(d8_reg[2] + qmul(u8_reg, q_t'(d8_reg[3] - d8_reg[2])));
            v9_reg  <= v8_reg;
        end
    end

    // stage 10: y lerp
    q_t n10_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            n10_reg <= q_t'(n09_reg + qmul(v9_reg, q_t'(n19_reg - n09_reg)));
    end

    assign noise = n10_reg[FRAC_BITS+3:0];

endmodule
